### design/rpna_pkg.sv
// ----------------------------------------------------------------------------
// rpna_pkg
// Shared types, constants and helpers for the radix-p number to ASCII block.
// ----------------------------------------------------------------------------
package rpna_pkg;

    localparam int INT_BITS        = 31;
    localparam int FRACTION_BITS   = 32;
    localparam int INT_DIGITS_MAX  = 32;
    localparam int INT_IDX_W       = 5;
    localparam int INT_CNT_W       = 6;
    localparam int DIV_BITS        = 32;
    localparam int DIV_BITS_CYCLE  = 8;
    localparam int DIV_STEPS       = DIV_BITS / DIV_BITS_CYCLE;
    localparam int CFG_W           = 5;
    localparam int CHAR_W          = 7;
    localparam int DIGIT_W         = 4;
    localparam int IN_TDATA_W      = 64;
    localparam int OUT_TDATA_W     = 8;

    localparam logic [CFG_W-1:0]  RADIX_MIN   = 5'd2;
    localparam logic [CFG_W-1:0]  RADIX_MAX   = 5'd16;
    localparam logic [CFG_W-1:0]  RADIX_RST   = 5'd10;
    localparam logic [CFG_W-1:0]  MAX_FRAC_RST = 5'd8;

    localparam logic [CHAR_W-1:0] CH_MINUS    = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT    = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO     = 7'd48;
    localparam logic [CHAR_W-1:0] CH_ALPHA_OFS = 7'd55;

    // register indexes on the config port
    typedef enum logic {
        REG_RADIX    = 1'b0,
        REG_MAX_FRAC = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IDIV,
        ST_FMUL,
        ST_SIGN,
        ST_INT,
        ST_POINT,
        ST_FRAC
    } t_state;

    typedef struct packed {
        logic                     show_minus;
        logic [INT_BITS-1:0]      mag;
        logic [FRACTION_BITS-1:0] frac;
    } t_item;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {3'b000, d};
        return (d <= 4'd9) ? (dx + CH_ZERO) : (dx + CH_ALPHA_OFS);
    endfunction

endpackage

### design/rpna_front.sv
// ----------------------------------------------------------------------------
// rpna_front
// Accepts number words, classifies the sign and holds them in a two-entry
// queue ahead of the conversion engine.
// ----------------------------------------------------------------------------
module rpna_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_neg,
    input  logic [rpna_pkg::INT_BITS-1:0]       i_mag,
    input  logic [rpna_pkg::FRACTION_BITS-1:0]  i_frac,
    output logic                                o_valid,
    input  logic                                i_ready,
    output rpna_pkg::t_item                     o_item
);

    rpna_pkg::t_item r_q [2];
    logic            r_wptr, n_wptr;
    logic            r_rptr, n_rptr;
    logic [1:0]      r_count, n_count;
    rpna_pkg::t_item w_item;
    logic            w_push, w_pop;

    // minus only for a nonzero value: negative zero prints as "0"
    always_comb begin
        w_item.show_minus = i_neg && ((i_mag != '0) || (i_frac != '0));
        w_item.mag        = i_mag;
        w_item.frac       = i_frac;
    end

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_q[r_rptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wptr  = w_push ? ~r_wptr : r_wptr;
        n_rptr  = w_pop ? ~r_rptr : r_rptr;
        n_count = r_count + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_item;
        end
    end

endmodule

### design/rpna_back.sv
// ----------------------------------------------------------------------------
// rpna_back
// Conversion engine: integer digits by serial division (8 bits a cycle),
// fraction digits by one multiply a cycle, then characters to an output word
// register.
// ----------------------------------------------------------------------------
module rpna_back #(
    parameter int FRACTION_DIGITS_MAX = 24,
    parameter int FCW = 5,
    parameter int FIW = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [rpna_pkg::CFG_W-1:0]        i_base,
    input  logic [FCW-1:0]                    i_limit,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  rpna_pkg::t_item                   i_item,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [rpna_pkg::CHAR_W-1:0]       o_char,
    output logic                              o_last
);

    localparam int PW = rpna_pkg::FRACTION_BITS + rpna_pkg::CFG_W;

    rpna_pkg::t_state                          r_state, n_state;
    logic [rpna_pkg::DIV_BITS-1:0]             r_sh, n_sh;
    logic [rpna_pkg::DIGIT_W-1:0]              r_rem, n_rem;
    logic [1:0]                                r_step, n_step;
    logic [rpna_pkg::INT_CNT_W-1:0]            r_nint, n_nint;
    logic [rpna_pkg::INT_IDX_W-1:0]            r_pos, n_pos;
    logic [rpna_pkg::FRACTION_BITS-1:0]        r_wf, n_wf;
    logic [FCW-1:0]                            r_nfrac, n_nfrac;
    logic [FCW-1:0]                            r_keep, n_keep;
    logic [FCW-1:0]                            r_fpos, n_fpos;
    logic                                      r_minus, n_minus;
    logic [rpna_pkg::DIGIT_W-1:0]              r_istore [rpna_pkg::INT_DIGITS_MAX];
    logic [rpna_pkg::DIGIT_W-1:0]              r_fstore [FRACTION_DIGITS_MAX];
    logic                                      r_out_valid;
    logic [rpna_pkg::CHAR_W-1:0]               r_out_char;
    logic                                      r_out_last;

    logic                                      w_out_free;
    logic                                      w_emit;
    logic [rpna_pkg::CHAR_W-1:0]               w_char;
    logic                                      w_last;
    logic [rpna_pkg::DIV_BITS_CYCLE-1:0]       w_qbits;
    logic [rpna_pkg::DIGIT_W-1:0]              w_rem;
    logic [rpna_pkg::DIV_BITS-1:0]             w_sh_next;
    logic                                      w_div_done;
    logic                                      w_frac_done;
    logic [PW-1:0]                             w_prod;
    logic [rpna_pkg::DIGIT_W-1:0]              w_fdigit;
    logic                                      w_istore_we;
    logic                                      w_fstore_we;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == rpna_pkg::ST_IDLE);

    // eight restoring steps on a remainder below the radix
    always_comb begin
        logic [rpna_pkg::DIGIT_W:0] t;
        w_rem   = r_rem;
        w_qbits = '0;
        for (int k = 0; k < rpna_pkg::DIV_BITS_CYCLE; k++) begin
            t = {w_rem, r_sh[rpna_pkg::DIV_BITS-1-k]};
            if (t >= i_base) begin
                w_qbits[rpna_pkg::DIV_BITS_CYCLE-1-k] = 1'b1;
                w_rem = rpna_pkg::DIGIT_W'(t - i_base);
            end else begin
                w_rem = t[rpna_pkg::DIGIT_W-1:0];
            end
        end
    end

    assign w_sh_next  = {r_sh[rpna_pkg::DIV_BITS-rpna_pkg::DIV_BITS_CYCLE-1:0], w_qbits};
    assign w_div_done = (r_step == 2'(rpna_pkg::DIV_STEPS - 1));
    assign w_prod     = PW'(r_wf) * PW'(i_base);
    assign w_fdigit   = w_prod[rpna_pkg::FRACTION_BITS +: rpna_pkg::DIGIT_W];
    assign w_frac_done = (r_wf == '0) || (r_nfrac >= i_limit);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rpna_pkg::ST_IDLE: begin
                if (i_valid) n_state = rpna_pkg::ST_IDIV;
            end
            rpna_pkg::ST_IDIV: begin
                if (w_div_done && (w_sh_next == '0)) n_state = rpna_pkg::ST_FMUL;
            end
            rpna_pkg::ST_FMUL: begin
                if (w_frac_done) n_state = r_minus ? rpna_pkg::ST_SIGN : rpna_pkg::ST_INT;
            end
            rpna_pkg::ST_SIGN: begin
                if (w_out_free) n_state = rpna_pkg::ST_INT;
            end
            rpna_pkg::ST_INT: begin
                if (w_out_free && (r_pos == '0)) begin
                    n_state = (r_keep != '0) ? rpna_pkg::ST_POINT : rpna_pkg::ST_IDLE;
                end
            end
            rpna_pkg::ST_POINT: begin
                if (w_out_free) n_state = rpna_pkg::ST_FRAC;
            end
            rpna_pkg::ST_FRAC: begin
                if (w_out_free && (r_fpos == r_keep - 1'b1)) n_state = rpna_pkg::ST_IDLE;
            end
            default: n_state = rpna_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_sh        = r_sh;
        n_rem       = r_rem;
        n_step      = r_step;
        n_nint      = r_nint;
        n_pos       = r_pos;
        n_wf        = r_wf;
        n_nfrac     = r_nfrac;
        n_keep      = r_keep;
        n_fpos      = r_fpos;
        n_minus     = r_minus;
        w_emit      = 1'b0;
        w_char      = rpna_pkg::CH_ZERO;
        w_last      = 1'b0;
        w_istore_we = 1'b0;
        w_fstore_we = 1'b0;
        case (r_state)
            rpna_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_sh    = {1'b0, i_item.mag};
                    n_rem   = '0;
                    n_step  = '0;
                    n_nint  = '0;
                    n_wf    = i_item.frac;
                    n_nfrac = '0;
                    n_keep  = '0;
                    n_minus = i_item.show_minus;
                end
            end
            rpna_pkg::ST_IDIV: begin
                n_sh  = w_sh_next;
                n_rem = w_rem;
                n_step = r_step + 2'd1;
                if (w_div_done) begin
                    w_istore_we = 1'b1;
                    n_nint = r_nint + 1'b1;
                    n_rem  = '0;
                    n_step = '0;
                end
            end
            rpna_pkg::ST_FMUL: begin
                n_pos = rpna_pkg::INT_IDX_W'(r_nint - 1'b1);
                if (!w_frac_done) begin
                    w_fstore_we = 1'b1;
                    n_wf    = w_prod[rpna_pkg::FRACTION_BITS-1:0];
                    n_nfrac = r_nfrac + 1'b1;
                    if (w_fdigit != '0) n_keep = r_nfrac + 1'b1;
                end
            end
            rpna_pkg::ST_SIGN: begin
                w_emit = w_out_free;
                w_char = rpna_pkg::CH_MINUS;
            end
            rpna_pkg::ST_INT: begin
                w_emit = w_out_free;
                w_char = rpna_pkg::digit_char(r_istore[r_pos]);
                w_last = (r_pos == '0) && (r_keep == '0);
                if (w_out_free && (r_pos != '0)) n_pos = r_pos - 1'b1;
            end
            rpna_pkg::ST_POINT: begin
                w_emit = w_out_free;
                w_char = rpna_pkg::CH_POINT;
                n_fpos = '0;
            end
            rpna_pkg::ST_FRAC: begin
                w_emit = w_out_free;
                w_char = rpna_pkg::digit_char(r_fstore[r_fpos[FIW-1:0]]);
                w_last = (r_fpos == r_keep - 1'b1);
                if (w_out_free) n_fpos = r_fpos + 1'b1;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpna_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_nint      <= '0;
            r_nfrac     <= '0;
            r_keep      <= '0;
            r_pos       <= '0;
            r_fpos      <= '0;
            r_minus     <= 1'b0;
            r_sh        <= '0;
            r_rem       <= '0;
            r_wf        <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_nint  <= n_nint;
            r_nfrac <= n_nfrac;
            r_keep  <= n_keep;
            r_pos   <= n_pos;
            r_fpos  <= n_fpos;
            r_minus <= n_minus;
            r_sh    <= n_sh;
            r_rem   <= n_rem;
            r_wf    <= n_wf;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_char <= w_char;
            r_out_last <= w_last;
        end
        if (w_istore_we) begin
            r_istore[r_nint[rpna_pkg::INT_IDX_W-1:0]] <= w_rem;
        end
        if (w_fstore_we) begin
            r_fstore[r_nfrac[FIW-1:0]] <= w_fdigit;
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpna_pkg::ST_IDIV) |-> ({1'b0, r_rem} < i_base))
        else $error("division remainder not below radix");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpna_pkg::ST_INT) |-> ({1'b0, r_pos} < r_nint))
        else $error("integer digit index beyond stored digits");

    a_keep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpna_pkg::ST_FMUL) |-> ((r_keep <= r_nfrac) && (r_nfrac <= i_limit)))
        else $error("fraction digit counts out of order");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> (r_state == rpna_pkg::ST_IDLE))
        else $error("engine busy after final character");

endmodule

### design/radix_p_number_to_ascii.sv
// ----------------------------------------------------------------------------
// radix_p_number_to_ascii
// Converts a sign, integer magnitude and Q0.32 fraction into base-p ASCII text.
// ----------------------------------------------------------------------------
// flow: the serial divider yields the integer digits, one multiply per fraction
//   digit follows, then the characters go out through the output register
// rate: 8 quotient bits a cycle in the divider and one character a cycle while the
//   output is not stalled; a new number starts only once the engine is idle
// reset: synchronous active low; radix 10, 8 fraction digits, queue empty
//   digit stores hold no reset value
module radix_p_number_to_ascii #(
    parameter int FRACTION_DIGITS_MAX = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic                                  i_cfg_idx,
    input  logic [rpna_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // negative flag [0], integer_magnitude [31:1], fraction_bits [63:32]
    input  logic [rpna_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // character [6:0], zero [7]
    output logic [rpna_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                                  o_m_tlast
);

    localparam int FCW = $clog2(FRACTION_DIGITS_MAX + 1);
    localparam int FIW = (FRACTION_DIGITS_MAX > 1) ? $clog2(FRACTION_DIGITS_MAX) : 1;

    logic [rpna_pkg::CFG_W-1:0]  r_radix;
    logic [rpna_pkg::CFG_W-1:0]  r_max_frac;
    logic [rpna_pkg::CFG_W-1:0]  w_base;
    logic [FCW-1:0]              w_limit;
    logic                        w_q_valid;
    logic                        w_q_ready;
    rpna_pkg::t_item             w_q_item;
    logic [rpna_pkg::CHAR_W-1:0] w_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= rpna_pkg::RADIX_RST;
            r_max_frac <= rpna_pkg::MAX_FRAC_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                rpna_pkg::REG_RADIX:    r_radix    <= i_cfg_wdata;
                rpna_pkg::REG_MAX_FRAC: r_max_frac <= i_cfg_wdata;
                default: r_radix <= r_radix;
            endcase
        end
    end

    assign w_base = (r_radix < rpna_pkg::RADIX_MIN) ? rpna_pkg::RADIX_MIN :
                    (r_radix > rpna_pkg::RADIX_MAX) ? rpna_pkg::RADIX_MAX : r_radix;
    assign w_limit = (r_max_frac > rpna_pkg::CFG_W'(FRACTION_DIGITS_MAX)) ?
                     FCW'(FRACTION_DIGITS_MAX) : FCW'(r_max_frac);

    rpna_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_neg   (i_s_tdata[0]),
        .i_mag   (i_s_tdata[rpna_pkg::INT_BITS:1]),
        .i_frac  (i_s_tdata[rpna_pkg::IN_TDATA_W-1:rpna_pkg::INT_BITS+1]),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    rpna_back #(
        .FRACTION_DIGITS_MAX (FRACTION_DIGITS_MAX),
        .FCW                 (FCW),
        .FIW                 (FIW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_base  (w_base),
        .i_limit (w_limit),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_item  (w_q_item),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_char  (w_char),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, w_char};

endmodule
